@@ rtl/krt_pkg.sv @@
`timescale 1ns / 1ps

package krt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		FUNC_INSERT  = 3'd0,
		FUNC_SEARCH  = 3'd1,
		FUNC_DELETE  = 3'd2,
		FUNC_UPDATE  = 3'd3,
		FUNC_DISPLAY = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		STATUS_DONE      = 3'd0,
		STATUS_RECORD    = 3'd1,
		STATUS_NOT_FOUND = 3'd2,
		STATUS_FULL      = 3'd3,
		STATUS_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_PULL,
		CELL_WRITE
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DISP
	} state_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [63:0]        name_mid;
		logic [23:0]        name_high;
		logic signed [31:0] score;
	} record_t;

	typedef struct packed {
		cell_op_t op;
		logic signed [31:0] key;
		record_t new_rec;
	} cell_cmd_t;

endpackage

@@ rtl/krt_cell.sv @@
`timescale 1ns / 1ps

module krt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  krt_pkg::cell_cmd_t cmd,
	input  logic            prev_valid,
	input  krt_pkg::record_t prev_rec,
	input  logic            next_valid,
	input  krt_pkg::record_t next_rec,
	input  logic            hit_in,
	output logic            hit_out,
	output logic            first_hit,
	output logic            valid,
	output krt_pkg::record_t rec
);
	import krt_pkg::*;

	logic    valid_q;
	record_t rec_q;
	logic    match;

	assign match     = valid_q && (rec_q.key == cmd.key);
	assign first_hit = match && !hit_in;
	assign hit_out   = hit_in || match;
	assign valid     = valid_q;
	assign rec       = rec_q;

	// Cells from the first matching one onwards close the gap on delete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				CELL_PUSH: valid_q <= prev_valid;
				CELL_PULL: if (hit_out) valid_q <= next_valid;
				CELL_HOLD, CELL_WRITE: valid_q <= valid_q;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_PUSH: rec_q <= prev_rec;
			CELL_PULL: if (hit_out) rec_q <= next_rec;
			CELL_WRITE: begin
				if (first_hit) begin
					rec_q.name_low  <= cmd.new_rec.name_low;
					rec_q.name_mid  <= cmd.new_rec.name_mid;
					rec_q.name_high <= cmd.new_rec.name_high;
					rec_q.score     <= cmd.new_rec.score;
				end
			end
			CELL_HOLD: rec_q <= rec_q;
			default: rec_q <= rec_q;
		endcase
	end

endmodule

@@ rtl/keyed_record_table_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   in_valid / in_stall  func, roll_key, name_bytes_low/mid/high, score
// result    out_valid / out_stall status, roll_key_out, name_*_out, score_out, last
//
// A request is registered while idle and executed in the EXEC state once the output
// register is free; the row of record cells shifts, matches and rewrites in that
// execute step. Display then gives one result per stored record from the DISP state.
// Reset clears the valid flag of every cell; record contents are not cleared.
// A stalled result holds in the output register while the next request is taken.

module keyed_record_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] roll_key,
	input  logic [63:0]        name_bytes_low,
	input  logic [63:0]        name_bytes_mid,
	input  logic [23:0]        name_bytes_high,
	input  logic signed [31:0] score,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] roll_key_out,
	output logic [63:0]        name_low_out,
	output logic [63:0]        name_mid_out,
	output logic [23:0]        name_high_out,
	output logic signed [31:0] score_out,
	output logic               last
);
	import krt_pkg::*;

	state_t     state_q, state_d;
	func_t      func_q;
	record_t    req_q;
	logic [IDX_W-1:0] idx_q, idx_d;

	logic       out_valid_q;
	status_t    status_q, status_d;
	record_t    out_rec_q, out_rec_d;
	logic       last_q, last_d;
	logic       load_out;
	logic       out_free;

	cell_cmd_t  cmd;
	cell_op_t   cell_op;
	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_first;
	logic [CAPACITY:0]   hit_chain;
	record_t    cell_rec [CAPACITY];
	logic [CAPACITY-1:0] sel;
	logic [CAPACITY-1:0] tail;
	record_t    rd_rec;
	logic       disp_last;
	logic       found, full, empty;

	assign cmd.op      = cell_op;
	assign cmd.key     = req_q.key;
	assign cmd.new_rec = req_q;
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic    pv, nv;
		record_t pr, nr;

		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pr = req_q;
		end else begin : g_body
			assign pv = cell_valid[i-1];
			assign pr = cell_rec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign nv = 1'b0;
			assign nr = '0;
			assign tail[i] = cell_valid[i];
		end else begin : g_mid
			assign nv = cell_valid[i+1];
			assign nr = cell_rec[i+1];
			assign tail[i] = cell_valid[i] && !cell_valid[i+1];
		end

		krt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (pv),
			.prev_rec   (pr),
			.next_valid (nv),
			.next_rec   (nr),
			.hit_in     (hit_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.first_hit  (cell_first[i]),
			.valid      (cell_valid[i]),
			.rec        (cell_rec[i])
		);

		assign sel[i] = (state_q == ST_DISP) ? (idx_q == IDX_W'(i)) : cell_first[i];
	end

	assign found = hit_chain[CAPACITY];
	assign full  = cell_valid[CAPACITY-1];
	assign empty = !cell_valid[0];
	assign disp_last = |(sel & tail);

	always_comb begin
		rd_rec = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_rec = rd_rec | (cell_rec[i] & {$bits(record_t){sel[i]}});
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q              <= func_t'(func);
			req_q.key           <= roll_key;
			req_q.name_low      <= name_bytes_low;
			req_q.name_mid      <= name_bytes_mid;
			req_q.name_high     <= name_bytes_high;
			req_q.score         <= score;
		end
		if (load_out) begin
			status_q  <= status_d;
			out_rec_q <= out_rec_d;
			last_q    <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cell_op   = CELL_HOLD;
		load_out  = 1'b0;
		status_d  = STATUS_DONE;
		out_rec_d = '0;
		last_d    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (func_q)
					FUNC_INSERT: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ST_IDLE;
							if (full) begin
								status_d = STATUS_FULL;
							end else begin
								cell_op = CELL_PUSH;
							end
						end
					end
					FUNC_SEARCH: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ST_IDLE;
							if (found) begin
								status_d  = STATUS_RECORD;
								out_rec_d = rd_rec;
							end else begin
								status_d = STATUS_NOT_FOUND;
							end
						end
					end
					FUNC_DELETE, FUNC_UPDATE: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ST_IDLE;
							if (found) begin
								cell_op = (func_q == FUNC_DELETE) ? CELL_PULL : CELL_WRITE;
							end else begin
								status_d = STATUS_NOT_FOUND;
							end
						end
					end
					FUNC_DISPLAY: begin
						if (empty) begin
							if (out_free) begin
								load_out = 1'b1;
								status_d = STATUS_EMPTY;
								state_d  = ST_IDLE;
							end
						end else begin
							idx_d   = '0;
							state_d = ST_DISP;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DISP: begin
				if (out_free) begin
					load_out  = 1'b1;
					status_d  = STATUS_RECORD;
					out_rec_d = rd_rec;
					last_d    = disp_last;
					if (disp_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign roll_key_out  = out_rec_q.key;
	assign name_low_out  = out_rec_q.name_low;
	assign name_mid_out  = out_rec_q.name_mid;
	assign name_high_out = out_rec_q.name_high;
	assign score_out     = out_rec_q.score;
	assign last          = last_q;

endmodule

@@ rtl/krt_checker.sv @@
`timescale 1ns / 1ps

module krt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic signed [31:0] roll_key_out,
	input logic [63:0]        name_low_out,
	input logic [63:0]        name_mid_out,
	input logic [23:0]        name_high_out,
	input logic signed [31:0] score_out,
	input logic               last
);
	import krt_pkg::*;

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last)
			&& $stable(roll_key_out) && $stable(score_out))
		else $error("stalled result changed");

	// The unit executes one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while the previous one executes");

	// Status-only results carry zero record fields.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_RECORD) |-> roll_key_out == '0 && score_out == '0
			&& name_low_out == '0 && name_mid_out == '0 && name_high_out == '0)
		else $error("record fields set on a status result");

	// Only display results may continue past the current one.
	a_last_only_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == STATUS_RECORD && in_stall)
		else $error("non-final result outside a display");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import krt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		status_t            status;
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [63:0]        name_mid;
		logic [23:0]        name_high;
		logic signed [31:0] score;
		logic               last;
	} reply_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         func;
	logic signed [31:0] roll_key;
	logic [63:0]        name_bytes_low;
	logic [63:0]        name_bytes_mid;
	logic [23:0]        name_bytes_high;
	logic signed [31:0] score;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic signed [31:0] roll_key_out;
	logic [63:0]        name_low_out;
	logic [63:0]        name_mid_out;
	logic [23:0]        name_high_out;
	logic signed [31:0] score_out;
	logic               last;

	record_t table_rec [CAPACITY];
	int      table_count = 0;
	reply_t  pending_replies[$];

	int   error_count   = 0;
	int   cycle_count   = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic stall_hold    = 1'b0;

	logic signed [31:0] key_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
		32'sd1, 32'sd42, 32'sd1000, 32'sh1234_5678};

	keyed_record_table_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.roll_key        (roll_key),
		.name_bytes_low  (name_bytes_low),
		.name_bytes_mid  (name_bytes_mid),
		.name_bytes_high (name_bytes_high),
		.score           (score),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.roll_key_out    (roll_key_out),
		.name_low_out    (name_low_out),
		.name_mid_out    (name_mid_out),
		.name_high_out   (name_high_out),
		.score_out       (score_out),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("[keyed_record_table_unit] ERROR");
		$finish;
	end

	task automatic push_status(input status_t code);
		pending_replies.push_back('{code, 32'sd0, 64'd0, 64'd0, 24'd0, 32'sd0, 1'b1});
	endtask

	task automatic push_record(input int idx, input logic is_last);
		pending_replies.push_back('{STATUS_RECORD, table_rec[idx].key, table_rec[idx].name_low,
			table_rec[idx].name_mid, table_rec[idx].name_high, table_rec[idx].score, is_last});
	endtask

	// Applies one request to the table copy and queues the results it gives.
	task automatic table_apply(input logic [2:0] op, input logic signed [31:0] key,
			input logic [63:0] nlo, input logic [63:0] nmid, input logic [23:0] nhi,
			input logic signed [31:0] sc);
		int      hit;
		record_t fresh;
		fresh.key       = key;
		fresh.name_low  = nlo;
		fresh.name_mid  = nmid;
		fresh.name_high = nhi;
		fresh.score     = sc;
		hit = -1;
		for (int i = 0; i < table_count; i++)
			if (hit < 0 && table_rec[i].key == key)
				hit = i;
		case (op)
			FUNC_INSERT: begin
				if (table_count >= CAPACITY) begin
					push_status(STATUS_FULL);
				end else begin
					for (int i = table_count; i > 0; i--)
						table_rec[i] = table_rec[i - 1];
					table_rec[0] = fresh;
					table_count++;
					push_status(STATUS_DONE);
				end
			end
			FUNC_SEARCH: begin
				if (hit < 0)
					push_status(STATUS_NOT_FOUND);
				else
					push_record(hit, 1'b1);
			end
			FUNC_DELETE: begin
				if (hit < 0) begin
					push_status(STATUS_NOT_FOUND);
				end else begin
					for (int i = hit; i + 1 < table_count; i++)
						table_rec[i] = table_rec[i + 1];
					table_count--;
					push_status(STATUS_DONE);
				end
			end
			FUNC_UPDATE: begin
				if (hit < 0) begin
					push_status(STATUS_NOT_FOUND);
				end else begin
					table_rec[hit].name_low  = nlo;
					table_rec[hit].name_mid  = nmid;
					table_rec[hit].name_high = nhi;
					table_rec[hit].score     = sc;
					push_status(STATUS_DONE);
				end
			end
			FUNC_DISPLAY: begin
				if (table_count == 0)
					push_status(STATUS_EMPTY);
				else
					for (int i = 0; i < table_count; i++)
						push_record(i, i == table_count - 1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_reply();
		reply_t want;
		if (pending_replies.size() == 0) begin
			$error("unexpected result: status %0d, key %0d", status, roll_key_out);
			error_count++;
			return;
		end
		want = pending_replies.pop_front();
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			error_count++;
		end
		if (roll_key_out !== want.key) begin
			$error("roll_key_out: expected %0d, got %0d", want.key, roll_key_out);
			error_count++;
		end
		if (name_low_out !== want.name_low) begin
			$error("name_low_out: expected %h, got %h", want.name_low, name_low_out);
			error_count++;
		end
		if (name_mid_out !== want.name_mid) begin
			$error("name_mid_out: expected %h, got %h", want.name_mid, name_mid_out);
			error_count++;
		end
		if (name_high_out !== want.name_high) begin
			$error("name_high_out: expected %h, got %h", want.name_high, name_high_out);
			error_count++;
		end
		if (score_out !== want.score) begin
			$error("score_out: expected %h, got %h", want.score, score_out);
			error_count++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, last);
			error_count++;
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_reply();
			out_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [63:0] rand_name64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [31:0] rand_score();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 32'sh8000_0000;
		if (r < 10)
			return 32'sh7fff_ffff;
		return 32'($urandom);
	endfunction

	// Mostly keys already held, so that searches, updates and deletes find something.
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55 && table_count > 0)
			return table_rec[$urandom_range(table_count - 1)].key;
		if (r < 85)
			return key_pool[$urandom_range(7)];
		return 32'($urandom);
	endfunction

	task automatic send_request(input logic [2:0] op, input logic signed [31:0] key,
			input logic [63:0] nlo, input logic [63:0] nmid, input logic [23:0] nhi,
			input logic signed [31:0] sc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= op;
		roll_key        <= key;
		name_bytes_low  <= nlo;
		name_bytes_mid  <= nmid;
		name_bytes_high <= nhi;
		score           <= sc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		table_apply(op, key, nlo, nmid, nhi, sc);
	endtask

	task automatic send_random_request();
		int         r;
		logic [2:0] op;
		r = $urandom_range(99);
		if (r < 3)
			op = 3'(5 + $urandom_range(2));
		else if (r < 10)
			op = FUNC_DISPLAY;
		else if (r < 45)
			op = FUNC_INSERT;
		else if (r < 65)
			op = FUNC_SEARCH;
		else if (r < 83)
			op = FUNC_DELETE;
		else
			op = FUNC_UPDATE;
		send_request(op, pick_key(), rand_name64(), rand_name64(), 24'($urandom), rand_score());
	endtask

	task automatic wait_all_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_request(FUNC_DISPLAY, 32'sd0, 64'd0, 64'd0, 24'd0, 32'sd0);
		send_request(FUNC_SEARCH, 32'sd42, 64'd0, 64'd0, 24'd0, 32'sd0);
		send_request(FUNC_DELETE, 32'sh8000_0000, 64'd0, 64'd0, 24'd0, 32'sd0);
		send_request(FUNC_UPDATE, 32'sh7fff_ffff, '1, '1, '1, 32'sh7fff_ffff);
		send_request(3'd5, 32'sd1, rand_name64(), rand_name64(), 24'($urandom), rand_score());
		send_request(3'd7, 32'sd1, rand_name64(), rand_name64(), 24'($urandom), rand_score());
		wait_all_replies();
	endtask

	task automatic test_fill_and_overflow();
		send_request(FUNC_INSERT, 32'sh8000_0000, 64'd0, 64'd0, 24'd0, 32'sh8000_0000);
		send_request(FUNC_INSERT, 32'sh7fff_ffff, '1, '1, '1, 32'sh7fff_ffff);
		for (int i = 2; i < CAPACITY; i++)
			send_request(FUNC_INSERT, (i % 3 == 0) ? 32'sd7 : 32'($urandom), rand_name64(),
				rand_name64(), 24'($urandom), rand_score());
		send_request(FUNC_INSERT, 32'sd99, rand_name64(), rand_name64(), 24'($urandom), 32'sd1);
		send_request(FUNC_DISPLAY, 32'sd0, 64'd0, 64'd0, 24'd0, 32'sd0);
		wait_all_replies();
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_random_request();
		wait_all_replies();
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				stall_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_hold <= 1'b0;
			end
		join_none
		repeat (12)
			send_random_request();
		wait_all_replies();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid        <= 1'b0;
		func            <= FUNC_SEARCH;
		roll_key        <= 32'sd0;
		name_bytes_low  <= 64'd0;
		name_bytes_mid  <= 64'd0;
		name_bytes_high <= 24'd0;
		score           <= 32'sd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_overflow();
		test_random_traffic(100, 6, 64);
		test_random_traffic(100, 64, 6);
		test_backpressure();
		test_random_traffic(100, 0, 0);

		if (error_count == 0)
			$display("[keyed_record_table_unit] OK");
		else
			$display("[keyed_record_table_unit] ERROR");
		$finish;
	end

endmodule
